/* hdl/sm3_hash_engine_defines.svh */
// sm3_hash_engine_defines.svh: assertion macros shared by the SM3 engine RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SM3_HASH_ENGINE_DEFINES_SVH
`define SM3_HASH_ENGINE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define SM3_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define SM3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/sm3_pkg.sv */
// sm3_pkg: types, constants and round functions for the SM3 engine.
// Depends on nothing.
`default_nettype none
package sm3_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned BlockWords = 16;
	localparam int unsigned Rounds = 64;
	localparam int unsigned DigestWords = 8;

	localparam logic [31:0] TLow = 32'h79cc4519;
	localparam logic [31:0] THigh = 32'h7a879d8a;
	localparam logic [7:0] PadByte = 8'h80;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0] byte_count;
		logic last_word;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic digest_last;
	} out_beat_t;

	typedef logic [7:0][31:0] state_t;

	localparam state_t Iv = {32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] p0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] p1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

	// Status between the word sequencer and the round unit.
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} cmp_ctl_t;

endpackage
`default_nettype wire

/* hdl/sm3_hash_engine.sv */
// SM3 hash engine with padding. Each message word beat is accepted, then stored,
// and the sixteenth word of a block also starts 64 compression rounds on the
// round unit (one round per cycle) and holds ready low until they finish.
// A last word adds padding words, each prepared and then stored, up to two
// compressions, then eight digest beats, one per cycle while out_ready is high.
// Depends on sm3_pkg, sm3_round and sm3_hash_engine_defines.svh.
`default_nettype none
`include "sm3_hash_engine_defines.svh"
module sm3_hash_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire sm3_pkg::in_beat_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output sm3_pkg::out_beat_t out_data
);

	typedef enum logic [2:0] {S_IDLE, S_PUSH, S_COMP, S_PAD, S_OUT} st_t;

	st_t st_q;
	logic [15:0][31:0] blk_q;
	logic [3:0] pos_q;
	logic [63:0] len_q;
	sm3_pkg::state_t cv_q;
	logic fin_q;
	logic [1:0] padph_q;
	logic [2:0] oidx_q;
	logic [31:0] pend_q;
	logic mark_q;
	logic [31:0] pad_w;

	logic r_busy, r_done;
	sm3_pkg::state_t r_out;
	logic r_start;

	sm3_round u_round (
		.clk(clk), .arst_n(arst_n), .start(r_start), .block(blk_q), .chain_in(cv_q),
		.busy(r_busy), .done(r_done), .chain_out(r_out)
	);

	logic [2:0] cnt;
	logic [31:0] mask, padbits;
	always_comb begin
		cnt = (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
		unique case (cnt)
			3'd0: begin mask = 32'h0; padbits = 32'h80000000; end
			3'd1: begin mask = 32'hff000000; padbits = 32'h00800000; end
			3'd2: begin mask = 32'hffff0000; padbits = 32'h00008000; end
			3'd3: begin mask = 32'hffffff00; padbits = 32'h00000080; end
			default: begin mask = 32'hffffffff; padbits = 32'h0; end
		endcase
		if (padph_q == 2'd1) pad_w = len_q[31:0];
		else if (pos_q == 4'd14) pad_w = len_q[63:32];
		else pad_w = 32'h0;
	end

	assign r_start = (st_q == S_COMP) && !r_busy && !r_done;
	assign in_ready = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign out_data.digest_word = cv_q[3'd7 - oidx_q];
	assign out_data.digest_last = (oidx_q == 3'd7);

	// pend holds a word awaiting push; fin marks padding in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			pos_q <= '0;
			len_q <= '0;
			cv_q <= sm3_pkg::Iv;
			fin_q <= 1'b0;
			padph_q <= '0;
			oidx_q <= '0;
			pend_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						if (!in_data.last_word && cnt == 3'd0) begin
							st_q <= S_IDLE;
						end else if (!in_data.last_word && cnt == 3'd4) begin
							pend_q <= in_data.message_word;
							len_q <= len_q + 64'd32;
							st_q <= S_PUSH;
						end else begin
							len_q <= len_q + {58'd0, cnt, 3'd0};
							fin_q <= 1'b1;
							padph_q <= 2'd0;
							st_q <= S_PUSH;
							pend_q <= (in_data.message_word & mask) | padbits;
						end
					end
				end
				S_PUSH: begin
					pos_q <= pos_q + 4'd1;
					if (pos_q == 4'd15) st_q <= S_COMP;
					else if (fin_q) st_q <= S_PAD;
					else st_q <= S_IDLE;
				end
				S_PAD: begin
					st_q <= S_PUSH;
					if (mark_q) begin
						pend_q <= {sm3_pkg::PadByte, 24'h0};
					end else begin
						pend_q <= pad_w;
						if (padph_q == 2'd1) padph_q <= 2'd2;
						else if (pos_q == 4'd14) padph_q <= 2'd1;
					end
				end
				S_COMP: begin
					if (r_done) begin
						cv_q <= r_out;
						if (fin_q && padph_q == 2'd2) begin
							st_q <= S_OUT;
							oidx_q <= '0;
						end else if (fin_q) st_q <= S_PAD;
						else st_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							st_q <= S_IDLE;
							cv_q <= sm3_pkg::Iv;
							pos_q <= '0;
							len_q <= '0;
							fin_q <= 1'b0;
							padph_q <= '0;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// A full last word needs the 0x80 marker word pushed after it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mark_q <= 1'b0;
		else if (st_q == S_IDLE && in_valid && cnt == 3'd4 && in_data.last_word) mark_q <= 1'b1;
		else if (st_q == S_PAD) mark_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (st_q == S_PUSH) blk_q[pos_q] <= pend_q;
	end

	`SM3_ASSERT_IMP(a_out_only, clk, arst_n, out_valid, !in_ready, "output while accepting")
	`SM3_ASSERT_IMP(a_comp_pos, clk, arst_n, st_q == S_COMP, pos_q == 4'd0, "compress mid-block")
	`SM3_ASSERT_NEXT(a_last_ret, clk, arst_n, out_valid && out_ready && out_data.digest_last, in_ready, "no re-arm")

endmodule
`default_nettype wire

/* hdl/sm3_round.sv */
// sm3_round: iterative SM3 compression, one round per cycle with a 16-word
// rolling message schedule. Depends on sm3_pkg and the assertion macros.
`default_nettype none
`include "sm3_hash_engine_defines.svh"
module sm3_round (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [15:0][31:0] block,
	input wire sm3_pkg::state_t chain_in,
	output logic busy,
	output logic done,
	output sm3_pkg::state_t chain_out
);

	logic [15:0][31:0] w_q;
	sm3_pkg::state_t v_q;
	logic [5:0] rnd_q;
	logic busy_q;
	logic done_q;

	logic [31:0] a, b, c, d, e, f, g, h;
	logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2, wnew, wj, wpj;
	logic low;

	always_comb begin
		{a, b, c, d, e, f, g, h} = v_q;
		low = (rnd_q[5:4] == 2'd0);
		t = low ? sm3_pkg::TLow : sm3_pkg::THigh;
		wj = w_q[0];
		wpj = w_q[0] ^ w_q[4];
		a12 = sm3_pkg::rotl(a, 5'd12);
		ss1 = sm3_pkg::rotl(a12 + e + sm3_pkg::rotl(t, rnd_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		ff = low ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
		gg = low ? (e ^ f ^ g) : ((e & f) | (~e & g));
		tt1 = ff + d + ss2 + wpj;
		tt2 = gg + h + ss1 + wj;
		wnew = sm3_pkg::p1(w_q[0] ^ w_q[7] ^ sm3_pkg::rotl(w_q[13], 5'd15))
			^ sm3_pkg::rotl(w_q[3], 5'd7) ^ w_q[10];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			w_q <= block;
			v_q <= chain_in;
		end else if (busy_q) begin
			w_q <= {wnew, w_q[15:1]};
			v_q <= {tt1, a, sm3_pkg::rotl(b, 5'd9), c, sm3_pkg::p0(tt2), e,
				sm3_pkg::rotl(f, 5'd19), g};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign chain_out = v_q ^ chain_in;

	`SM3_ASSERT_NEXT(a_done_ends, clk, arst_n, busy_q && rnd_q == 6'd63, done_q && !busy_q, "round overrun")
	`SM3_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, !busy_q, "done while busy")
	`SM3_ASSERT_IMP(a_idle_rnd, clk, arst_n, !busy_q, rnd_q == 6'd0, "round count not parked")

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// tb_top: self-checking bench for sm3_hash_engine, random and directed message words.
// A local SM3 digest predictor models padding and compression; depends on sm3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	sm3_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	sm3_pkg::out_beat_t out_data;

	sm3_hash_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [31:0] chain[8];
	logic [31:0] blk[16];
	logic [3:0] wpos;
	logic [63:0] nbits;
	sm3_pkg::in_beat_t word_q[$];
	sm3_pkg::out_beat_t digest_q[$];
	int errors = 0;

	function automatic logic [31:0] rl(input logic [31:0] x, input int n);
		n = n % 32;
		return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
	endfunction

	task automatic compress();
		logic [31:0] w[68];
		logic [31:0] a, b, c, d, e, f, g, h, t, a12, ss1, ss2, ff, gg, t1, t2;
		for (int j = 0; j < 16; j++) w[j] = blk[j];
		for (int j = 16; j < 68; j++) begin
			t = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
			w[j] = (t ^ rl(t, 15) ^ rl(t, 23)) ^ rl(w[j-13], 7) ^ w[j-6];
		end
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (int j = 0; j < 64; j++) begin
			t = (j < 16) ? sm3_pkg::TLow : sm3_pkg::THigh;
			a12 = rl(a, 12);
			ss1 = rl(a12 + e + rl(t, j), 7);
			ss2 = ss1 ^ a12;
			ff = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
			gg = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
			t1 = ff + d + ss2 + (w[j] ^ w[j+4]);
			t2 = gg + h + ss1 + w[j];
			d = c; c = rl(b, 9); b = a; a = t1;
			h = g; g = rl(f, 19); f = e; e = t2 ^ rl(t2, 9) ^ rl(t2, 17);
		end
		chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
		chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
	endtask

	task automatic push_blk(input logic [31:0] w);
		blk[wpos] = w;
		wpos = wpos + 4'd1;
		if (wpos == 4'd0) compress();
	endtask

	task automatic rearm();
		for (int k = 0; k < 8; k++) chain[k] = sm3_pkg::Iv[7-k];
		wpos = '0;
		nbits = '0;
	endtask

	task automatic predict_digest(input sm3_pkg::in_beat_t it);
		int cnt;
		int sh;
		logic [31:0] mask;
		sm3_pkg::out_beat_t o;
		cnt = (it.byte_count > 3'd4) ? 4 : int'(it.byte_count);
		if (!it.last_word) begin
			if (cnt == 0) return;
			if (cnt == 4) begin
				push_blk(it.message_word);
				nbits += 64'd32;
				return;
			end
		end
		nbits += 64'(cnt * 8);
		if (cnt == 4) begin
			push_blk(it.message_word);
			push_blk({sm3_pkg::PadByte, 24'h0});
		end else begin
			sh = 8 * (4 - cnt);
			mask = (cnt == 0) ? 32'h0 : (32'hffffffff << sh);
			push_blk((it.message_word & mask) | (32'({sm3_pkg::PadByte}) << (sh - 8)));
		end
		while (wpos != 4'd14) push_blk(32'h0);
		push_blk(nbits[63:32]);
		push_blk(nbits[31:0]);
		for (int k = 0; k < 8; k++) begin
			o.digest_word = chain[k];
			o.digest_last = (k == 7);
			digest_q.push_back(o);
		end
		rearm();
	endtask

	function automatic sm3_pkg::in_beat_t mk(input logic [31:0] m, input int c, input bit l);
		sm3_pkg::in_beat_t b;
		b.message_word = m;
		b.byte_count = 3'(c);
		b.last_word = l;
		return b;
	endfunction

	// sender: bursts and gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) predict_digest(in_data);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (word_q.size() > 0) begin
					in_data <= word_q.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long hold-off counter
	int cyc = 0;
	int hold_left = 0;
	bit held = 1'b0;
	always @(posedge clk) begin
		if (arst_n) begin
			cyc <= cyc + 1;
			if (!held && cyc == 600) begin
				held <= 1'b1;
				hold_left <= 1500;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// receiver: check beats, stall pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					$display("%0t unexpected digest beat: actual %h/%b", $time,
						out_data.digest_word, out_data.digest_last);
					errors++;
				end else if (out_data !== digest_q[0]) begin
					$display("%0t digest mismatch: expected %h/%b actual %h/%b", $time,
						digest_q[0].digest_word, digest_q[0].digest_last,
						out_data.digest_word, out_data.digest_last);
					errors++;
					void'(digest_q.pop_front());
				end else begin
					void'(digest_q.pop_front());
				end
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
			end else if ((cyc / 500) % 3 == 2) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	initial begin
		int n;
		int len;
		rearm();
		// empty message, short tails, full-word tail, ignored empties, clamp
		word_q.push_back(mk(32'h0, 0, 1));
		word_q.push_back(mk(32'h61626300, 3, 1));
		word_q.push_back(mk(32'hffffffff, 1, 1));
		word_q.push_back(mk(32'hffffffff, 2, 0));
		word_q.push_back(mk(32'h12345678, 0, 0));
		word_q.push_back(mk(32'hdeadbeef, 4, 1));
		word_q.push_back(mk(32'haaaaaaaa, 7, 0));
		word_q.push_back(mk(32'h55555555, 5, 1));
		for (int i = 0; i < 13; i++) word_q.push_back(mk(32'hffffffff, 4, 0));
		word_q.push_back(mk(32'h0, 0, 1));
		for (int i = 0; i < 14; i++) word_q.push_back(mk(32'h0, 4, 0));
		word_q.push_back(mk(32'h01020304, 6, 1));
		n = word_q.size();
		while (n < 420) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 16);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 15) == 0)
					word_q.push_back(mk($urandom, ($urandom_range(0, 1) ? 0 : $urandom_range(5, 7)),
						0));
				else
					word_q.push_back(mk($urandom, 4, 0));
			end
			if ($urandom_range(0, 9) == 0)
				word_q.push_back(mk($urandom, $urandom_range(1, 3), 0));
			else
				word_q.push_back(mk($urandom, $urandom_range(0, 7), 1));
			n += len + 1;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (word_q.size() == 0 && !in_valid);
		wait (digest_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("[sm3_hash_engine] OK");
		else
			$display("[sm3_hash_engine] ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("[sm3_hash_engine] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
